// ----- rtl/assert_macros.svh -----
// Assertion macros used by the frame checker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define OFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define OFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ofc_pkg.sv -----
// ----------------------------------------------------------------------------
// ofc_pkg
// Types, constants and the CRC-8 byte step of the odometry frame checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ofc_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 14;
  localparam int IDX_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [IDX_W-1:0] POS_SYNC   = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_LEN    = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_REPLY  = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_FWD_HI = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_FWD_LO = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_LAT_HI = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_LAT_LO = IDX_W'(7);
  localparam logic [IDX_W-1:0] POS_TRN_HI = IDX_W'(10);
  localparam logic [IDX_W-1:0] POS_TRN_LO = IDX_W'(11);
  localparam logic [IDX_W-1:0] POS_LAST   = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] POS_IDLE   = IDX_W'(0);

  localparam logic [BYTE_W-1:0] LEN_BYTE    = BYTE_W'(FRAME_BYTES);
  localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'h5A;
  localparam logic [BYTE_W-1:0] REPLY_RESET = 8'h12;
  localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h8C;
  localparam logic [BYTE_W-1:0] CRC_INIT    = 8'h00;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HEADER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CRC    = 2'd2;

  // Byte held in the input register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;
  } stage_t;

  // Decoded result of one frame
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic signed [WORD_W-1:0] forward_speed;
    logic signed [WORD_W-1:0] lateral_speed;
    logic signed [WORD_W-1:0] turn_rate;
  } result_t;

  // One byte of reflected CRC-8, polynomial 0x8C
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/ofc_in_if.sv -----
// ----------------------------------------------------------------------------
// ofc_in_if
// Byte channel into the frame checker: valid, ready and one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ofc_in_if;
  logic                      valid;
  logic                      ready;
  logic [ofc_pkg::BYTE_W-1:0] rx_byte;
  logic                      frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ----- rtl/ofc_out_if.sv -----
// ----------------------------------------------------------------------------
// ofc_out_if
// Result channel of the frame checker: valid, ready, status and speeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ofc_out_if;
  logic                               valid;
  logic                               ready;
  logic [ofc_pkg::STATUS_W-1:0]       status;
  logic signed [ofc_pkg::WORD_W-1:0]  forward_speed;
  logic signed [ofc_pkg::WORD_W-1:0]  lateral_speed;
  logic signed [ofc_pkg::WORD_W-1:0]  turn_rate;

  modport source (output valid, output status, output forward_speed,
                  output lateral_speed, output turn_rate, input ready);
  modport sink   (input valid, input status, input forward_speed,
                  input lateral_speed, input turn_rate, output ready);
endinterface

// ----- rtl/ofc_in_stage.sv -----
// ----------------------------------------------------------------------------
// ofc_in_stage
// Input register: captures one byte transfer and holds it until the core
// takes it; refills in the same cycle so a byte can enter every cycle while the core keeps taking them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofc_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ofc_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic                        in_frame_start,
  input  logic                        take,
  output ofc_pkg::stage_t             stage
);

  logic                       vld_r, vld_nxt;
  logic [ofc_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic                       start_r, start_nxt;
  logic                       load;

  // Accept when empty or when the held byte leaves this cycle
  assign in_ready = !vld_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    vld_nxt   = vld_r;
    byte_nxt  = byte_r;
    start_nxt = start_r;
    if (load) begin
      vld_nxt   = 1'b1;
      byte_nxt  = in_rx_byte;
      start_nxt = in_frame_start;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  // Clear valid under reset; payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    start_r <= start_nxt;
  end

  assign stage.valid       = vld_r;
  assign stage.rx_byte     = byte_r;
  assign stage.frame_start = start_r;

endmodule

// ----- rtl/ofc_frame_core.sv -----
// ----------------------------------------------------------------------------
// ofc_frame_core
// Frame state, header checks, CRC step, word capture and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofc_frame_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ofc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ofc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ofc_pkg::stage_t                stage,
  output logic                           take,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ofc_pkg::result_t               res
);

  localparam int IW = ofc_pkg::IDX_W;
  localparam int BW = ofc_pkg::BYTE_W;
  localparam int WW = ofc_pkg::WORD_W;

  logic [BW-1:0] sync_r, reply_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [BW-1:0] crc_r, crc_nxt;
  logic          hdr_r, hdr_nxt;
  logic [WW-1:0] fwd_r, fwd_nxt, lat_r, lat_nxt, trn_r, trn_nxt;
  logic          out_vld_r, out_vld_nxt;
  ofc_pkg::result_t res_r, res_nxt;

  logic          active;
  logic [IW-1:0] pos;
  logic [BW-1:0] crc_base;
  logic          hdr_cur;
  logic [BW-1:0] b;

  // Take a byte when the result register is free or draining
  assign take = stage.valid && (!out_vld_r || res_ready);
  assign b    = stage.rx_byte;

  always_comb begin
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    hdr_nxt     = hdr_r;
    fwd_nxt     = fwd_r;
    lat_nxt     = lat_r;
    trn_nxt     = trn_r;
    out_vld_nxt = out_vld_r && !res_ready;
    res_nxt     = res_r;

    active   = stage.frame_start || (idx_r != ofc_pkg::POS_IDLE);
    pos      = stage.frame_start ? ofc_pkg::POS_SYNC : idx_r;
    crc_base = stage.frame_start ? ofc_pkg::CRC_INIT : crc_r;

    // Header checks on sync, length and reply code bytes
    hdr_cur = stage.frame_start ? 1'b0 : hdr_r;
    if (pos == ofc_pkg::POS_SYNC && b != sync_r) begin
      hdr_cur = 1'b1;
    end
    if (pos == ofc_pkg::POS_LEN && b != ofc_pkg::LEN_BYTE) begin
      hdr_cur = 1'b1;
    end
    if (pos == ofc_pkg::POS_REPLY && b != reply_r) begin
      hdr_cur = 1'b1;
    end

    if (take && active) begin
      hdr_nxt = hdr_cur;

      // Capture big-endian velocity words
      case (pos)
        ofc_pkg::POS_FWD_HI: fwd_nxt = {b, fwd_r[BW-1:0]};
        ofc_pkg::POS_FWD_LO: fwd_nxt = {fwd_r[WW-1:BW], b};
        ofc_pkg::POS_LAT_HI: lat_nxt = {b, lat_r[BW-1:0]};
        ofc_pkg::POS_LAT_LO: lat_nxt = {lat_r[WW-1:BW], b};
        ofc_pkg::POS_TRN_HI: trn_nxt = {b, trn_r[BW-1:0]};
        ofc_pkg::POS_TRN_LO: trn_nxt = {trn_r[WW-1:BW], b};
        default: ;
      endcase

      if (pos < ofc_pkg::POS_LAST) begin
        // Advance through the frame body
        crc_nxt = ofc_pkg::crc8_step(crc_base, b);
        idx_nxt = pos + IW'(1);
      end else begin
        // Last byte carries the CRC: issue the result and drop to idle
        idx_nxt     = ofc_pkg::POS_IDLE;
        out_vld_nxt = 1'b1;
        if (hdr_cur) begin
          res_nxt.status = ofc_pkg::ST_HEADER;
        end else if (crc_r != b) begin
          res_nxt.status = ofc_pkg::ST_CRC;
        end else begin
          res_nxt.status = ofc_pkg::ST_OK;
        end
        if (!hdr_cur && crc_r == b) begin
          res_nxt.forward_speed = fwd_r;
          res_nxt.lateral_speed = lat_r;
          res_nxt.turn_rate     = trn_r;
        end else begin
          res_nxt.forward_speed = '0;
          res_nxt.lateral_speed = '0;
          res_nxt.turn_rate     = '0;
        end
      end
    end
  end

  // Configuration registers and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r    <= ofc_pkg::SYNC_RESET;
      reply_r   <= ofc_pkg::REPLY_RESET;
      idx_r     <= ofc_pkg::POS_IDLE;
      crc_r     <= ofc_pkg::CRC_INIT;
      hdr_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          ofc_pkg::CFG_SYNC:  sync_r  <= cfg_data;
          ofc_pkg::CFG_REPLY: reply_r <= cfg_data;
          default: ;
        endcase
      end
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      hdr_r     <= hdr_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Captured words and result payload
  always_ff @(posedge clk) begin
    fwd_r <= fwd_nxt;
    lat_r <= lat_nxt;
    trn_r <= trn_nxt;
    res_r <= res_nxt;
  end

  assign res_valid = out_vld_r;
  assign res       = res_r;

endmodule

// ----- rtl/odometry_frame_checker.sv -----
// ----------------------------------------------------------------------------
// odometry_frame_checker: one byte per cycle unless stalled; input register to result register.
// Result valid is registered when the core takes the last byte from the input register.
// A stalled result holds the core; the input register then fills and stops.
// Synchronous active-low reset clears frame state and valids and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module odometry_frame_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ofc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ofc_pkg::CFG_DATA_W-1:0] cfg_data,
  ofc_in_if.sink                         in_if,
  ofc_out_if.source                      out_if
);

  ofc_pkg::stage_t  stage;
  ofc_pkg::result_t res;
  logic             take;
  logic             res_valid;

  // Input register
  ofc_in_stage u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_rx_byte     (in_if.rx_byte),
    .in_frame_start (in_if.frame_start),
    .take           (take),
    .stage          (stage)
  );

  // Frame parsing and result register
  ofc_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .take      (take),
    .res_valid (res_valid),
    .res_ready (out_if.ready),
    .res       (res)
  );

  assign out_if.valid         = res_valid;
  assign out_if.status        = res.status;
  assign out_if.forward_speed = res.forward_speed;
  assign out_if.lateral_speed = res.lateral_speed;
  assign out_if.turn_rate     = res.turn_rate;

  // Failed frames carry no speeds
  `OFC_ASSERT_IMP(a_fail_zero, clk, rst_n, res_valid && res.status != ofc_pkg::ST_OK, res.forward_speed == '0 && res.lateral_speed == '0 && res.turn_rate == '0, "failed frame with nonzero speed")
  // A stalled result blocks the core
  `OFC_ASSERT_IMP(a_stall_block, clk, rst_n, res_valid && !out_if.ready, !take, "core took a byte while result stalled")
  // A byte not taken stays in the input register
  `OFC_ASSERT_NXT(a_stage_hold, clk, rst_n, stage.valid && !take, stage.valid && $stable(stage.rx_byte) && $stable(stage.frame_start), "input register lost a byte")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the odometry frame checker. A byte-level decoder
// follows every accepted transfer and predicts each frame's status and
// speeds; the result channel is compared field by field against it. Directed
// frames cover good, header, length, reply code and CRC failures, dropped
// frames and stray bytes, then random frames run under several register
// settings with random gaps on the byte side and random stalls on results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ofc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_GAP       = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  // Decoder of the byte stream and store of the frame results still due
  class frame_scoreboard;
    logic [BYTE_W-1:0] sync_val;
    logic [BYTE_W-1:0] reply_val;
    logic [IDX_W-1:0]  byte_pos;
    logic [BYTE_W-1:0] crc_acc;
    logic              hdr_bad;
    logic [WORD_W-1:0] fwd_word;
    logic [WORD_W-1:0] lat_word;
    logic [WORD_W-1:0] trn_word;
    result_t           due_results[$];
    int                results_made;
    int                errors;

    function new();
      sync_val     = SYNC_RESET;
      reply_val    = REPLY_RESET;
      byte_pos     = POS_IDLE;
      crc_acc      = CRC_INIT;
      hdr_bad      = 1'b0;
      fwd_word     = '0;
      lat_word     = '0;
      trn_word     = '0;
      results_made = 0;
      errors       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SYNC:  sync_val = val;
        CFG_REPLY: reply_val = val;
        default: ;
      endcase
    endfunction

    // Reflected CRC-8, fed one bit at a time, least significant first
    function logic [BYTE_W-1:0] crc_after(logic [BYTE_W-1:0] crc, logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] r;
      logic              fb;
      r = crc;
      for (int k = 0; k < BYTE_W; k++) begin
        fb = r[0] ^ data[k];
        r  = r >> 1;
        if (fb) begin
          r = r ^ CRC_POLY;
        end
      end
      return r;
    endfunction

    // Advance the frame state by one accepted byte
    function void note_byte(logic [BYTE_W-1:0] data, logic start);
      logic [IDX_W-1:0] p;
      result_t          r;
      if (start) begin
        p       = POS_SYNC;
        crc_acc = CRC_INIT;
        hdr_bad = 1'b0;
      end else if (byte_pos == POS_IDLE) begin
        return;
      end else begin
        p = byte_pos;
      end

      if (p == POS_SYNC && data != sync_val) hdr_bad = 1'b1;
      if (p == POS_LEN && data != LEN_BYTE) hdr_bad = 1'b1;
      if (p == POS_REPLY && data != reply_val) hdr_bad = 1'b1;

      case (p)
        POS_FWD_HI: fwd_word[15:8] = data;
        POS_FWD_LO: fwd_word[7:0]  = data;
        POS_LAT_HI: lat_word[15:8] = data;
        POS_LAT_LO: lat_word[7:0]  = data;
        POS_TRN_HI: trn_word[15:8] = data;
        POS_TRN_LO: trn_word[7:0]  = data;
        default: ;
      endcase

      if (p != POS_LAST) begin
        crc_acc  = crc_after(crc_acc, data);
        byte_pos = p + 1'b1;
        return;
      end

      // Last byte: the header check wins over the CRC check
      byte_pos = POS_IDLE;
      r = '0;
      if (hdr_bad) begin
        r.status = ST_HEADER;
      end else if (crc_acc != data) begin
        r.status = ST_CRC;
      end else begin
        r.status        = ST_OK;
        r.forward_speed = fwd_word;
        r.lateral_speed = lat_word;
        r.turn_rate     = trn_word;
      end
      due_results.push_back(r);
      results_made++;
    endfunction

    // Compare one result transfer with the oldest result due
    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("unexpected result: status %0d fwd %0d lat %0d turn %0d",
                   got.status, got.forward_speed, got.lateral_speed, got.turn_rate);
        end
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status || got.forward_speed !== want.forward_speed ||
          got.lateral_speed !== want.lateral_speed || got.turn_rate !== want.turn_rate) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("result mismatch: status exp %0d got %0d, fwd exp %0d got %0d",
                   want.status, got.status, want.forward_speed, got.forward_speed);
          $display("  lat exp %0d got %0d, turn exp %0d got %0d",
                   want.lateral_speed, got.lateral_speed, want.turn_rate, got.turn_rate);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    cycle_count;
  int                    sender_mode;
  logic [BYTE_W-1:0]     frame_buf [FRAME_BYTES];
  frame_scoreboard       sb;

  ofc_in_if  in_ch ();
  ofc_out_if out_ch ();

  odometry_frame_checker u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Abort a run that hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Mode 0: no idling, mode 1: any gap, otherwise an occasional gap
  function automatic int pick_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, MAX_GAP);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_GAP) : 0;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Fill the frame buffer and close it with the right or a corrupted CRC
  function automatic void build_frame(logic [BYTE_W-1:0] sync_b, logic [BYTE_W-1:0] len_b,
                                      logic [BYTE_W-1:0] code_b, logic [WORD_W-1:0] fwd,
                                      logic [WORD_W-1:0] lat, logic [WORD_W-1:0] trn,
                                      logic crc_bad);
    logic [BYTE_W-1:0] acc;
    frame_buf[0]  = sync_b;
    frame_buf[1]  = len_b;
    frame_buf[2]  = BYTE_W'($urandom);
    frame_buf[3]  = code_b;
    frame_buf[4]  = fwd[15:8];
    frame_buf[5]  = fwd[7:0];
    frame_buf[6]  = lat[15:8];
    frame_buf[7]  = lat[7:0];
    frame_buf[8]  = BYTE_W'($urandom);
    frame_buf[9]  = BYTE_W'($urandom);
    frame_buf[10] = trn[15:8];
    frame_buf[11] = trn[7:0];
    frame_buf[12] = BYTE_W'($urandom);
    acc = CRC_INIT;
    for (int k = 0; k < FRAME_BYTES - 1; k++) begin
      acc = sb.crc_after(acc, frame_buf[k]);
    end
    frame_buf[FRAME_BYTES-1] = crc_bad ? acc ^ BYTE_W'($urandom_range(1, 255)) : acc;
  endfunction

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(logic [BYTE_W-1:0] data, logic start);
    int gap;
    gap = pick_gap(sender_mode);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.rx_byte     <= data;
    in_ch.frame_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(data, start);
  endtask

  task automatic send_frame(int n);
    for (int k = 0; k < n; k++) begin
      send_byte(frame_buf[k], k == 0);
    end
  endtask

  // Bytes without a frame start, ignored while the checker is idle
  task automatic send_noise(int n);
    for (int k = 0; k < n; k++) begin
      send_byte(BYTE_W'($urandom), 1'b0);
    end
  endtask

  // Hold the byte side until every result due has arrived
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // One random frame, mostly well formed; returns the count of frame bytes sent
  task automatic random_frame(output int n);
    int                kind;
    logic [BYTE_W-1:0] sync_b;
    logic [BYTE_W-1:0] len_b;
    logic [BYTE_W-1:0] code_b;
    logic              crc_bad;
    kind        = $urandom_range(0, 99);
    sender_mode = $urandom_range(0, 2);
    sync_b      = sb.sync_val;
    len_b       = LEN_BYTE;
    code_b      = sb.reply_val;
    crc_bad     = 1'b0;
    n           = FRAME_BYTES;
    if (kind >= 70 && kind < 76) begin
      sync_b = sync_b ^ BYTE_W'($urandom_range(1, 255));
    end else if (kind >= 76 && kind < 81) begin
      len_b = len_b ^ BYTE_W'($urandom_range(1, 255));
    end else if (kind >= 81 && kind < 86) begin
      code_b = code_b ^ BYTE_W'($urandom_range(1, 255));
    end else if (kind >= 86 && kind < 93) begin
      crc_bad = 1'b1;
    end else if (kind >= 93 && kind < 96) begin
      code_b  = code_b ^ BYTE_W'($urandom_range(1, 255));
      crc_bad = 1'b1;
    end else if (kind >= 96) begin
      // cut short: the next frame start drops it
      n = $urandom_range(1, FRAME_BYTES - 1);
    end
    build_frame(sync_b, len_b, code_b, pick_word(), pick_word(), pick_word(), crc_bad);
    send_frame(n);
    if ($urandom_range(0, 4) == 0) begin
      send_noise($urandom_range(1, 3));
    end
  endtask

  task automatic run_frames(int byte_target, int result_target);
    int sent;
    int n;
    int made0;
    sent  = 0;
    made0 = sb.results_made;
    while (sent < byte_target || sb.results_made - made0 < result_target) begin
      random_frame(n);
      sent += n;
    end
  endtask

  // Result side: random stalls, check every transfer
  initial begin
    int      stall;
    int      mode;
    result_t got;
    out_ch.ready = 1'b0;
    mode = 0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        mode = $urandom_range(0, 2);
      end
      stall = pick_gap(mode);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.status        = out_ch.status;
      got.forward_speed = out_ch.forward_speed;
      got.lateral_speed = out_ch.lateral_speed;
      got.turn_rate     = out_ch.turn_rate;
      sb.check_result(got);
    end
  end

  // Stimulus
  initial begin
    sb                = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_SYNC;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = '0;
    in_ch.frame_start = 1'b0;
    sender_mode       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset register values
    build_frame(SYNC_RESET, LEN_BYTE, REPLY_RESET, 16'h7FFF, 16'h8000, 16'h0000, 1'b0);
    send_frame(FRAME_BYTES);
    send_noise(2);
    build_frame(SYNC_RESET, LEN_BYTE, REPLY_RESET, 16'hFFFF, 16'h0001, 16'h8000, 1'b0);
    send_frame(FRAME_BYTES);
    sender_mode = 1;
    build_frame(SYNC_RESET ^ 8'hFF, LEN_BYTE, REPLY_RESET, 16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    send_frame(FRAME_BYTES);
    build_frame(SYNC_RESET, LEN_BYTE ^ 8'h01, REPLY_RESET, 16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    send_frame(FRAME_BYTES);
    build_frame(SYNC_RESET, LEN_BYTE, REPLY_RESET ^ 8'h80, 16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    send_frame(FRAME_BYTES);
    build_frame(SYNC_RESET, LEN_BYTE, REPLY_RESET, 16'h1234, 16'h5678, 16'h9ABC, 1'b1);
    send_frame(FRAME_BYTES);
    build_frame(SYNC_RESET ^ 8'h01, LEN_BYTE, REPLY_RESET, 16'h0F0F, 16'hF0F0, 16'h00FF, 1'b1);
    send_frame(FRAME_BYTES);
    sender_mode = 2;
    // frames dropped by a new frame start, one of them on the CRC byte
    build_frame(SYNC_RESET, LEN_BYTE, REPLY_RESET, 16'h4000, 16'hC000, 16'h0100, 1'b0);
    send_frame(7);
    send_frame(FRAME_BYTES - 1);
    send_frame(FRAME_BYTES);
    send_noise(3);
    drain_results();

    // Register settings, extremes first
    write_reg(CFG_SYNC, 8'h00);
    write_reg(CFG_REPLY, 8'hFF);
    run_frames(80, 5);
    drain_results();
    write_reg(CFG_SYNC, 8'hFF);
    write_reg(CFG_REPLY, 8'h00);
    run_frames(80, 5);
    drain_results();
    write_reg(CFG_SYNC, CFG_DATA_W'($urandom));
    write_reg(CFG_REPLY, CFG_DATA_W'($urandom));
    run_frames(40, 3);
    drain_results();
    run_frames(40, 3);
    drain_results();
    write_reg(CFG_SYNC, SYNC_RESET);
    write_reg(CFG_REPLY, REPLY_RESET);
    run_frames(80, 5);
    drain_results();

    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- odometry_frame_checker.f -----
+incdir+rtl
rtl/ofc_pkg.sv
rtl/ofc_in_if.sv
rtl/ofc_out_if.sv
rtl/ofc_in_stage.sv
rtl/ofc_frame_core.sv
rtl/odometry_frame_checker.sv
tb/tb_top.sv
